// ===== hdl/assert_macros.svh =====
// Assertion shorthands for the symbol table checkers.
// Both expect signals named clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SST_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SST_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sst_pkg.sv =====
package sst_pkg;

  // Default sizing of the table.
  localparam int DEF_ENTRIES    = 64;
  localparam int DEF_SCOPES     = 16;
  localparam int DEF_NAME_CHARS = 32;

  // Fixed port widths.
  localparam int FUNC_W     = 3;
  localparam int KEY_WORD_W = 64;
  localparam int KEY_WORDS  = 4;
  localparam int TOKEN_W    = 16;
  localparam int EIDX_W     = 6;
  localparam int RIDX_W     = 6;
  localparam int STATUS_W   = 3;
  localparam int DEPTH_W    = 4;

  // Operation codes carried by the func field.
  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 3'd0,
    FN_LOOKUP = 3'd1,
    FN_PUSH   = 3'd2,
    FN_POP    = 3'd3,
    FN_READ   = 3'd4
  } func_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_t;

endpackage

// ===== hdl/sst_ram.sv =====
module sst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, read-first, registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hdl/scoped_symbol_table_unit.sv =====
// Insert and lookup go from accept through dispatch to a scan of the current scope, which stops
// at the first match or at the scope's end; the name memory is scanned one entry per cycle. Push
// and unused codes go from dispatch to the result; pop and read pass a memory wait unless refused.
// A new word is accepted in the cycle after the result register is loaded, even while that
// result still waits to be taken. Reset (synchronous, active low) opens an empty outermost
// scope; the memories are not cleared, since only entries below the current count are read.
module scoped_symbol_table_unit
  import sst_pkg::*;
#(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int SCOPES     = DEF_SCOPES,
  parameter int NAME_CHARS = DEF_NAME_CHARS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [KEY_WORD_W-1:0] in_key_word0,
  input  logic [KEY_WORD_W-1:0] in_key_word1,
  input  logic [KEY_WORD_W-1:0] in_key_word2,
  input  logic [KEY_WORD_W-1:0] in_key_word3,
  input  logic [TOKEN_W-1:0]    in_token_in,
  input  logic [EIDX_W-1:0]     in_entry_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_found,
  output logic [RIDX_W-1:0]     out_result_index,
  output logic [TOKEN_W-1:0]    out_token_out,
  output logic [STATUS_W-1:0]   out_status,
  output logic [DEPTH_W-1:0]    out_depth_out
);

  localparam int SLOTS  = SCOPES * ENTRIES;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int LVL_W  = (SCOPES > 1) ? $clog2(SCOPES) : 1;
  localparam int NAME_W = 8 * NAME_CHARS;
  localparam int CMP_W  = (CNT_W > EIDX_W) ? CNT_W : EIDX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_POPW,
    S_RDW,
    S_DONE
  } state_t;

  state_t                state_r, state_nxt;
  logic [FUNC_W-1:0]     func_r, func_nxt;
  logic [NAME_W-1:0]     key_r, key_nxt;
  logic [TOKEN_W-1:0]    tok_in_r, tok_in_nxt;
  logic [EIDX_W-1:0]     ei_r, ei_nxt;
  logic [LVL_W-1:0]      level_r, level_nxt;
  logic [SLOT_W-1:0]     base_r, base_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      p_r, p_nxt;
  logic                  rv_r, rv_nxt;
  logic [IDX_W-1:0]      q_r, q_nxt;
  logic                  res_found_r, res_found_nxt;
  logic [IDX_W-1:0]      res_idx_r, res_idx_nxt;
  logic [TOKEN_W-1:0]    res_tok_r, res_tok_nxt;
  status_t               res_status_r, res_status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [RIDX_W-1:0]     out_idx_r, out_idx_nxt;
  logic [TOKEN_W-1:0]    out_tok_r, out_tok_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [DEPTH_W-1:0]    out_depth_r, out_depth_nxt;

  // Memory ports.
  logic                  slot_we;
  logic [SLOT_W-1:0]     slot_addr;
  logic [NAME_W-1:0]     name_rd;
  logic [TOKEN_W-1:0]    tok_rd;
  logic                  cnt_we;
  logic [LVL_W-1:0]      cnt_addr;
  logic [CNT_W-1:0]      cnt_rd;

  // Helpers.
  logic [KEY_WORDS*KEY_WORD_W-1:0] raw_key;
  logic [NAME_CHARS-1:0]           nz;
  logic [NAME_CHARS-1:0]           keep;
  logic [NAME_W-1:0]               canon_key;
  logic                            issue;
  logic                            hit;
  logic [CMP_W-1:0]                ei_ext;
  logic [CMP_W-1:0]                cnt_ext;
  logic [LVL_W+DEPTH_W-1:0]        lvl_ext;
  logic [IDX_W+RIDX_W-1:0]         ridx_ext;

  // Canonical key: a character is kept only if it and all before it are nonzero.
  always_comb begin
    raw_key = {in_key_word3, in_key_word2, in_key_word1, in_key_word0};
    for (int c = 0; c < NAME_CHARS; c++) begin
      nz[c] = |raw_key[8*c +: 8];
    end
    for (int c = 0; c < NAME_CHARS; c++) begin
      keep[c] = &(nz | ~({NAME_CHARS{1'b1}} >> (NAME_CHARS - 1 - c)));
      canon_key[8*c +: 8] = keep[c] ? raw_key[8*c +: 8] : 8'h00;
    end
  end

  assign issue    = (p_r < cnt_r);
  assign hit      = rv_r && (name_rd == key_r);
  assign ei_ext   = CMP_W'(ei_r);
  assign cnt_ext  = CMP_W'(cnt_r);
  assign lvl_ext  = {{DEPTH_W{1'b0}}, level_r};
  assign ridx_ext = {{RIDX_W{1'b0}}, res_idx_r};

  assign in_ready = (state_r == S_IDLE);

  // Sequencer: accept, dispatch, scan the scope, then hand the result to the output word.
  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    key_nxt        = key_r;
    tok_in_nxt     = tok_in_r;
    ei_nxt         = ei_r;
    level_nxt      = level_r;
    base_nxt       = base_r;
    cnt_nxt        = cnt_r;
    p_nxt          = p_r;
    rv_nxt         = rv_r;
    q_nxt          = q_r;
    res_found_nxt  = res_found_r;
    res_idx_nxt    = res_idx_r;
    res_tok_nxt    = res_tok_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_found_nxt  = out_found_r;
    out_idx_nxt    = out_idx_r;
    out_tok_nxt    = out_tok_r;
    out_status_nxt = out_status_r;
    out_depth_nxt  = out_depth_r;
    slot_we        = 1'b0;
    slot_addr      = base_r + SLOT_W'(p_r[IDX_W-1:0]);
    cnt_we         = 1'b0;
    cnt_addr       = level_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt       = in_func;
          key_nxt        = canon_key;
          tok_in_nxt     = in_token_in;
          ei_nxt         = in_entry_index;
          p_nxt          = '0;
          rv_nxt         = 1'b0;
          res_found_nxt  = 1'b0;
          res_idx_nxt    = '0;
          res_tok_nxt    = '0;
          res_status_nxt = ST_OK;
          state_nxt      = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (func_r)
          FN_INSERT, FN_LOOKUP: begin
            state_nxt = S_SCAN;
          end
          FN_PUSH: begin
            if (level_r == LVL_W'(SCOPES - 1)) begin
              res_status_nxt = ST_OVERFLOW;
            end else begin
              // Save this scope's count for the matching pop.
              cnt_we    = 1'b1;
              level_nxt = level_r + 1'b1;
              base_nxt  = base_r + SLOT_W'(ENTRIES);
              cnt_nxt   = '0;
            end
            state_nxt = S_DONE;
          end
          FN_POP: begin
            if (level_r == '0) begin
              res_status_nxt = ST_UNDERFLOW;
              state_nxt      = S_DONE;
            end else begin
              cnt_addr  = level_r - 1'b1;
              level_nxt = level_r - 1'b1;
              base_nxt  = base_r - SLOT_W'(ENTRIES);
              state_nxt = S_POPW;
            end
          end
          FN_READ: begin
            if (ei_ext >= cnt_ext) begin
              res_status_nxt = ST_BAD_INDEX;
              state_nxt      = S_DONE;
            end else begin
              slot_addr = base_r + SLOT_W'(ei_ext[IDX_W-1:0]);
              state_nxt = S_RDW;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      // One read issued per cycle; the compare sees the entry whose read was issued in the previous cycle.
      S_SCAN: begin
        rv_nxt = issue;
        q_nxt  = p_r[IDX_W-1:0];
        if (issue) begin
          p_nxt = p_r + 1'b1;
        end
        if (hit) begin
          res_found_nxt = 1'b1;
          res_idx_nxt   = q_r;
          res_tok_nxt   = tok_rd;
          rv_nxt        = 1'b0;
          state_nxt     = S_DONE;
        end else if (!issue) begin
          rv_nxt = 1'b0;
          if (func_r == FN_INSERT) begin
            if (cnt_r == CNT_W'(ENTRIES)) begin
              res_status_nxt = ST_FULL;
            end else begin
              // Append the new name at the end of the scope.
              slot_we     = 1'b1;
              slot_addr   = base_r + SLOT_W'(cnt_r[IDX_W-1:0]);
              cnt_nxt     = cnt_r + 1'b1;
              res_idx_nxt = cnt_r[IDX_W-1:0];
            end
          end
          state_nxt = S_DONE;
        end
      end

      S_POPW: begin
        cnt_nxt   = cnt_rd;
        state_nxt = S_DONE;
      end

      S_RDW: begin
        res_tok_nxt = tok_rd;
        state_nxt   = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = res_found_r;
          out_idx_nxt    = ridx_ext[RIDX_W-1:0];
          out_tok_nxt    = res_tok_r;
          out_status_nxt = res_status_r;
          out_depth_nxt  = lvl_ext[DEPTH_W-1:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      level_r     <= '0;
      base_r      <= '0;
      cnt_r       <= '0;
      p_r         <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      base_r      <= base_nxt;
      cnt_r       <= cnt_nxt;
      p_r         <= p_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r       <= func_nxt;
    key_r        <= key_nxt;
    tok_in_r     <= tok_in_nxt;
    ei_r         <= ei_nxt;
    q_r          <= q_nxt;
    res_found_r  <= res_found_nxt;
    res_idx_r    <= res_idx_nxt;
    res_tok_r    <= res_tok_nxt;
    res_status_r <= res_status_nxt;
    out_found_r  <= out_found_nxt;
    out_idx_r    <= out_idx_nxt;
    out_tok_r    <= out_tok_nxt;
    out_status_r <= out_status_nxt;
    out_depth_r  <= out_depth_nxt;
  end

  // Names and tokens share one slot address: scope base plus entry index.
  sst_ram #(
    .WIDTH(NAME_W),
    .DEPTH(SLOTS)
  ) u_name_ram (
    .clk  (clk),
    .we   (slot_we),
    .addr (slot_addr),
    .wdata(key_r),
    .rdata(name_rd)
  );

  sst_ram #(
    .WIDTH(TOKEN_W),
    .DEPTH(SLOTS)
  ) u_token_ram (
    .clk  (clk),
    .we   (slot_we),
    .addr (slot_addr),
    .wdata(tok_in_r),
    .rdata(tok_rd)
  );

  // Saved entry counts of the enclosing scopes.
  sst_ram #(
    .WIDTH(CNT_W),
    .DEPTH(SCOPES)
  ) u_count_ram (
    .clk  (clk),
    .we   (cnt_we),
    .addr (cnt_addr),
    .wdata(cnt_r),
    .rdata(cnt_rd)
  );

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_result_index = out_idx_r;
  assign out_token_out    = out_tok_r;
  assign out_status       = out_status_r;
  assign out_depth_out    = out_depth_r;

endmodule

// ===== hdl/sst_checker.sv =====
`include "assert_macros.svh"

module sst_checker
  import sst_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_found,
  input logic [RIDX_W-1:0]   out_result_index,
  input logic [TOKEN_W-1:0]  out_token_out,
  input logic [STATUS_W-1:0] out_status,
  input logic [DEPTH_W-1:0]  out_depth_out
);

  logic [DEPTH_W-1:0] prev_depth_r;
  logic [DEPTH_W-1:0] depth_up;
  logic [DEPTH_W-1:0] depth_dn;

  // Depth reported by the last delivered word; the outermost scope after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_depth_r <= '0;
    end else if (out_valid && out_ready) begin
      prev_depth_r <= out_depth_out;
    end
  end

  assign depth_up = prev_depth_r + 1'b1;
  assign depth_dn = prev_depth_r - 1'b1;

  `SST_ASSERT_IMP(a_found_ok, out_valid && out_found, out_status == ST_OK, "match with error status")
  `SST_ASSERT_IMP(a_full_zero, out_valid && (out_status == ST_FULL), !out_found && (out_result_index == '0) && (out_token_out == '0), "full table result not cleared")
  `SST_ASSERT_IMP(a_depth_step, out_valid, (out_depth_out == prev_depth_r) || (out_depth_out == depth_up) || (out_depth_out == depth_dn), "scope depth moved by more than one")
  `SST_ASSERT_IMP(a_refused_hold, out_valid && ((out_status == ST_OVERFLOW) || (out_status == ST_UNDERFLOW)), out_depth_out == prev_depth_r, "refused push or pop changed depth")
  `SST_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_token_out) && $stable(out_result_index) && $stable(out_status), "stalled result word changed")

endmodule

bind scoped_symbol_table_unit sst_checker u_sst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_found       (out_found),
  .out_result_index(out_result_index),
  .out_token_out   (out_token_out),
  .out_status      (out_status),
  .out_depth_out   (out_depth_out)
);

// ===== verif/testbench.sv =====
module testbench;
  import sst_pkg::*;

  localparam int ENTRY_CNT     = DEF_ENTRIES;
  localparam int SCOPE_CNT     = DEF_SCOPES;
  localparam int NAME_BYTES    = DEF_NAME_CHARS;
  localparam int KEY_W         = KEY_WORDS * KEY_WORD_W;
  localparam int POOL_SIZE     = 80;
  localparam int WORD_GOAL     = 1800;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = DEF_ENTRIES + 16;

  // Function codes that the block decodes as no operation.
  localparam logic [FUNC_W-1:0] FN_SPARE5 = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE7 = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [KEY_W-1:0]   key;
    logic [TOKEN_W-1:0] token;
    logic [EIDX_W-1:0]  eidx;
    logic               hold;
  } sym_word_t;

  typedef struct packed {
    logic                found;
    logic [RIDX_W-1:0]   index;
    logic [TOKEN_W-1:0]  token;
    logic [STATUS_W-1:0] status;
    logic [DEPTH_W-1:0]  depth;
  } sym_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [FUNC_W-1:0]     in_func = '0;
  logic [KEY_WORD_W-1:0] in_key_word0 = '0;
  logic [KEY_WORD_W-1:0] in_key_word1 = '0;
  logic [KEY_WORD_W-1:0] in_key_word2 = '0;
  logic [KEY_WORD_W-1:0] in_key_word3 = '0;
  logic [TOKEN_W-1:0]    in_token_in = '0;
  logic [EIDX_W-1:0]     in_entry_index = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_found;
  logic [RIDX_W-1:0]     out_result_index;
  logic [TOKEN_W-1:0]    out_token_out;
  logic [STATUS_W-1:0]   out_status;
  logic [DEPTH_W-1:0]    out_depth_out;

  scoped_symbol_table_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_key_word0     (in_key_word0),
    .in_key_word1     (in_key_word1),
    .in_key_word2     (in_key_word2),
    .in_key_word3     (in_key_word3),
    .in_token_in      (in_token_in),
    .in_entry_index   (in_entry_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_found        (out_found),
    .out_result_index (out_result_index),
    .out_token_out    (out_token_out),
    .out_status       (out_status),
    .out_depth_out    (out_depth_out)
  );

  always #5 clk = ~clk;

  // Pending words, predicted results and handshake counters.
  sym_word_t   word_q[$];
  sym_result_t result_q[$];
  sym_word_t   cur_word;
  int          issued_cnt = 0;
  int          taken_cnt = 0;
  int          stim_total = 0;
  int          err_cnt = 0;
  int          cycle_cnt = 0;
  int          snd_idle;
  int          rcv_idle;
  bit          hold_next = 1'b0;

  // Shadow copy of the scope stack.
  int                 cur_level = 0;
  int                 scope_count[SCOPE_CNT] = '{default: 0};
  logic [KEY_W-1:0]   name_mem[SCOPE_CNT][ENTRY_CNT];
  logic [TOKEN_W-1:0] token_mem[SCOPE_CNT][ENTRY_CNT];

  // Name pool used to build matching keys.
  logic [KEY_W-1:0] pool_name[POOL_SIZE];
  int               pool_len[POOL_SIZE];

  // A name ends at its first zero character; everything past it is ignored.
  function automatic logic [KEY_W-1:0] canon_name(logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] name;
    bit ended;
    name = '0;
    ended = 1'b0;
    for (int c = 0; c < NAME_BYTES; c++) begin
      if (raw[c*8 +: 8] == 8'h00) ended = 1'b1;
      if (!ended) name[c*8 +: 8] = raw[c*8 +: 8];
    end
    return name;
  endfunction

  // Applies one word to the shadow scope stack and returns its result.
  function automatic sym_result_t apply_word(sym_word_t w);
    sym_result_t r;
    logic [KEY_W-1:0] name;
    int hit;
    int cnt;
    r = '0;
    cnt = scope_count[cur_level];
    case (w.func)
      FN_INSERT, FN_LOOKUP: begin
        name = canon_name(w.key);
        hit = -1;
        for (int p = 0; p < cnt; p++)
          if (hit < 0 && name_mem[cur_level][p] == name) hit = p;
        if (hit >= 0) begin
          r.found = 1'b1;
          r.index = hit[RIDX_W-1:0];
          r.token = token_mem[cur_level][hit];
        end else if (w.func == FN_INSERT) begin
          if (cnt >= ENTRY_CNT) begin
            r.status = ST_FULL;
          end else begin
            name_mem[cur_level][cnt] = name;
            token_mem[cur_level][cnt] = w.token;
            scope_count[cur_level] = cnt + 1;
            r.index = cnt[RIDX_W-1:0];
          end
        end
      end
      FN_PUSH: begin
        if (cur_level >= SCOPE_CNT - 1) begin
          r.status = ST_OVERFLOW;
        end else begin
          cur_level++;
          scope_count[cur_level] = 0;
        end
      end
      FN_POP: begin
        if (cur_level == 0) r.status = ST_UNDERFLOW;
        else cur_level--;
      end
      FN_READ: begin
        if (int'(w.eidx) >= cnt) r.status = ST_BAD_INDEX;
        else r.token = token_mem[cur_level][w.eidx];
      end
      default: ;
    endcase
    r.depth = cur_level[DEPTH_W-1:0];
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    logic [KEY_W-1:0] k;
    for (int i = 0; i < KEY_W / 32; i++) k[i*32 +: 32] = $urandom;
    return k;
  endfunction

  // Pool name, sometimes with random bytes after its terminating zero.
  function automatic logic [KEY_W-1:0] pool_key(int i);
    logic [KEY_W-1:0] k;
    k = pool_name[i];
    if (pool_len[i] < NAME_BYTES - 1 && $urandom_range(0, 1))
      for (int b = pool_len[i] + 1; b < NAME_BYTES; b++) k[b*8 +: 8] = 8'($urandom_range(0, 255));
    return k;
  endfunction

  // Mostly a small set of names so that scopes see repeats.
  function automatic int pick_name();
    return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 15) : $urandom_range(0, POOL_SIZE - 1);
  endfunction

  function automatic logic [EIDX_W-1:0] pick_index();
    return $urandom_range(0, 1) ? EIDX_W'($urandom_range(0, 7)) : EIDX_W'($urandom_range(0, 63));
  endfunction

  task automatic add_word(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                          input logic [TOKEN_W-1:0] t, input logic [EIDX_W-1:0] e);
    sym_word_t w;
    w.func = f;
    w.key = k;
    w.token = t;
    w.eidx = e;
    w.hold = hold_next;
    hold_next = 1'b0;
    word_q.push_back(w);
  endtask

  task automatic add_noise();
    add_word(FUNC_W'($urandom_range(FN_INSERT, FN_SPARE7)), rand_key(),
             TOKEN_W'($urandom_range(0, 65535)), EIDX_W'($urandom_range(0, 63)));
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  // Idle rates per phase of the run.
  always_comb begin
    if (issued_cnt < stim_total / 3) begin
      snd_idle = 25;
      rcv_idle = 58;
    end else if (issued_cnt < 2 * stim_total / 3) begin
      snd_idle = 58;
      rcv_idle = 25;
    end else begin
      snd_idle = 0;
      rcv_idle = 0;
    end
  end

  // Driver: predicts each accepted word and presents the next one.
  always @(posedge clk) begin : drive_words
    bit taking;
    int outstanding;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      taking = in_valid && in_ready;
      if (taking) begin
        result_q.push_back(apply_word(cur_word));
        issued_cnt <= issued_cnt + 1;
      end
      outstanding = issued_cnt - taken_cnt + (taking ? 1 : 0);
      if (!in_valid || in_ready) begin
        if (word_q.size() > 0 && $urandom_range(0, 99) >= snd_idle &&
            !(word_q[0].hold && outstanding != 0)) begin
          cur_word = word_q.pop_front();
          in_valid <= 1'b1;
          in_func <= cur_word.func;
          in_key_word0 <= cur_word.key[63:0];
          in_key_word1 <= cur_word.key[127:64];
          in_key_word2 <= cur_word.key[191:128];
          in_key_word3 <= cur_word.key[255:192];
          in_token_in <= cur_word.token;
          in_entry_index <= cur_word.eidx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result word with the oldest prediction.
  always @(posedge clk) begin : check_results
    sym_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (taken_cnt == issued_cnt) begin
          report_mismatch("result word with no prediction waiting");
        end else begin
          want = result_q.pop_front();
          if (out_found !== want.found)
            report_mismatch($sformatf("word %0d found: expected %0h got %0h",
                                      taken_cnt, want.found, out_found));
          if (out_result_index !== want.index)
            report_mismatch($sformatf("word %0d result_index: expected %0h got %0h",
                                      taken_cnt, want.index, out_result_index));
          if (out_token_out !== want.token)
            report_mismatch($sformatf("word %0d token_out: expected %0h got %0h",
                                      taken_cnt, want.token, out_token_out));
          if (out_status !== want.status)
            report_mismatch($sformatf("word %0d status: expected %0h got %0h",
                                      taken_cnt, want.status, out_status));
          if (out_depth_out !== want.depth)
            report_mismatch($sformatf("word %0d depth_out: expected %0h got %0h",
                                      taken_cnt, want.depth, out_depth_out));
          taken_cnt <= taken_cnt + 1;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stimulus: directed words, then random sequences; then wait for the tail.
  initial begin : gen_stimulus
    logic [KEY_W-1:0] key_a;
    bit dup;
    int kind;
    int n;
    int r;
    int tmp;
    int j;
    int order[POOL_SIZE];

    // Distinct pool names; the first is the empty name.
    for (int i = 0; i < POOL_SIZE; i++) begin
      do begin
        pool_len[i] = (i == 0) ? 0 : $urandom_range(1, NAME_BYTES);
        pool_name[i] = '0;
        for (int b = 0; b < pool_len[i]; b++)
          pool_name[i][b*8 +: 8] = 8'($urandom_range(1, 255));
        dup = 1'b0;
        for (int k = 0; k < i; k++) if (pool_name[k] == pool_name[i]) dup = 1'b1;
      end while (dup);
    end

    // Directed part: empty table, underflow, empty and full-length names,
    // names with bytes after the terminator, unused codes, parent scope kept.
    add_word(FN_READ, '0, '0, '0);
    add_word(FN_POP, '0, '0, '0);
    add_word(FN_LOOKUP, '0, '0, '0);
    add_word(FN_INSERT, '0, '1, '0);
    add_word(FN_INSERT, '1, '0, '1);
    add_word(FN_INSERT, '1, 16'h1234, '0);
    key_a = rand_key();
    key_a[15:0] = 16'h0041;
    add_word(FN_INSERT, key_a, 16'h5a5a, '0);
    key_a = rand_key();
    key_a[15:0] = 16'h0041;
    add_word(FN_LOOKUP, key_a, '0, '0);
    add_word(FN_LOOKUP, '0, '0, '0);
    add_word(FN_READ, '0, '0, 6'd2);
    add_word(FN_READ, '0, '0, 6'd3);
    add_word(FN_READ, '1, '1, '1);
    add_word(FN_SPARE5, '1, '1, '1);
    add_word(FN_SPARE6, '1, '1, '1);
    add_word(FN_SPARE7, '1, '1, '1);
    add_word(FN_PUSH, '0, '0, '0);
    add_word(FN_LOOKUP, '1, '0, '0);
    add_word(FN_READ, '0, '0, '0);
    add_word(FN_INSERT, '1, 16'haaaa, '0);
    add_word(FN_POP, '0, '0, '0);
    add_word(FN_LOOKUP, '1, '0, '0);
    add_word(FN_READ, '0, '0, 6'd1);

    // Random sequences; the first one waits for the directed results.
    hold_next = 1'b1;
    while (word_q.size() < WORD_GOAL) begin
      if ($urandom_range(0, 14) == 0) hold_next = 1'b1;
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        // Nested scope with a random body; the push or the pop is sometimes missing.
        if ($urandom_range(0, 9) != 0)
          add_word(FN_PUSH, rand_key(), TOKEN_W'($urandom_range(0, 65535)), pick_index());
        n = $urandom_range(3, 16);
        for (int i = 0; i < n; i++) begin
          r = $urandom_range(0, 99);
          if (r < 40) add_word(FN_INSERT, pool_key(pick_name()),
                               TOKEN_W'($urandom_range(0, 65535)), pick_index());
          else if (r < 70) add_word(FN_LOOKUP, pool_key(pick_name()),
                                    TOKEN_W'($urandom_range(0, 65535)), pick_index());
          else if (r < 90) add_word(FN_READ, rand_key(), TOKEN_W'($urandom_range(0, 65535)),
                                    pick_index());
          else add_word($urandom_range(0, 1) ? FN_PUSH : FN_POP, rand_key(),
                        TOKEN_W'($urandom_range(0, 65535)), pick_index());
        end
        if ($urandom_range(0, 99) >= 15)
          add_word(FN_POP, rand_key(), TOKEN_W'($urandom_range(0, 65535)), pick_index());
      end else if (kind < 72) begin
        // Fill a scope past its capacity with distinct names.
        for (int i = 0; i < POOL_SIZE; i++) order[i] = i;
        for (int i = POOL_SIZE - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        if ($urandom_range(0, 4) != 0) add_word(FN_PUSH, '0, '0, '0);
        for (int i = 0; i < ENTRY_CNT + 2; i++)
          add_word(FN_INSERT, pool_key(order[i]), TOKEN_W'($urandom_range(0, 65535)),
                   pick_index());
        for (int i = 0; i < 6; i++) begin
          if ($urandom_range(0, 1))
            add_word(FN_LOOKUP, pool_key($urandom_range(0, POOL_SIZE - 1)), '0, '0);
          else add_word(FN_READ, '0, '0, EIDX_W'($urandom_range(0, 63)));
        end
        add_word(FN_POP, '0, '0, '0);
      end else if (kind < 80) begin
        // Run past the deepest scope and back out past the outermost one.
        for (int i = 0; i < SCOPE_CNT + 1; i++)
          add_word(FN_PUSH, rand_key(), TOKEN_W'($urandom_range(0, 65535)),
                   EIDX_W'($urandom_range(0, 63)));
        for (int i = 0; i < SCOPE_CNT + 1; i++)
          add_word(FN_POP, rand_key(), TOKEN_W'($urandom_range(0, 65535)),
                   EIDX_W'($urandom_range(0, 63)));
      end else begin
        // Noise: any code with arbitrary content.
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) add_noise();
      end
    end
    stim_total = word_q.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (!(issued_cnt == stim_total && taken_cnt == stim_total)) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (taken_cnt != issued_cnt) report_mismatch("predictions left over at end of run");
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/sst_pkg.sv
hdl/sst_ram.sv
hdl/scoped_symbol_table_unit.sv
hdl/sst_checker.sv
verif/testbench.sv
